// ----- src/ecal_pkg.sv -----
// Shared types, constants and the control-store program of the epoch
// seconds to calendar converter. No dependencies.
package ecal_pkg;

  localparam int SEC_W   = 31;
  localparam int YEAR_W  = 11;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int YRS_W   = 7;
  localparam int STEP_W  = 5;
  localparam int SHIFT_W = 3;
  localparam int INC_W   = 7;
  localparam int MAX_SHIFT = 5;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1970;
  localparam logic [MON_W-1:0]  FEBRUARY   = 4'd1;
  localparam logic [MON_W-1:0]  LAST_MONTH = 4'd11;

  localparam logic [SEC_W-1:0] SECS_PER_MIN       = 31'd60;
  localparam logic [SEC_W-1:0] SECS_PER_HOUR      = 31'd3600;
  localparam logic [SEC_W-1:0] SECS_PER_DAY       = 31'd86400;
  localparam logic [SEC_W-1:0] SECS_PER_YEAR      = 31'd31536000;
  localparam logic [SEC_W-1:0] SECS_PER_LEAP_YEAR = 31'd31622400;
  localparam logic [SEC_W-1:0] SECS_PER_QUAD      = 31'd126230400;

  // Day counts modulo 7, used to keep the weekday running.
  localparam logic [WDAY_W-1:0] QUAD_MOD7      = 3'd5;
  localparam logic [WDAY_W-1:0] YEAR_MOD7      = 3'd1;
  localparam logic [WDAY_W-1:0] LEAP_YEAR_MOD7 = 3'd2;
  localparam logic [WDAY_W-1:0] DAY_MOD7       = 3'd1;
  localparam logic [WDAY_W-1:0] NONE_MOD7      = 3'd0;

  typedef enum logic [2:0] {
    SRC_QUAD,
    SRC_YEAR,
    SRC_MONTH,
    SRC_DAY,
    SRC_HOUR,
    SRC_MIN
  } src_t;

  typedef struct packed {
    src_t               src;
    logic [SHIFT_W-1:0] shift;
    logic               rpt;
    logic               last;
  } ctl_t;

  typedef struct packed {
    logic load;
    logic exec;
    ctl_t ctl;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic taken;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } seq_state_t;

  function automatic ctl_t mk_ctl(input src_t src, input logic [SHIFT_W-1:0] shift,
                                  input logic rpt, input logic last);
    ctl_t c;
    c.src   = src;
    c.shift = shift;
    c.rpt   = rpt;
    c.last  = last;
    return c;
  endfunction

  // Each step compares the remaining seconds against a base amount scaled
  // by a power of two and subtracts it when it fits. Repeating steps stay
  // put while the subtraction is taken.
  function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_t c;
    case (step)
      5'd0:    c = mk_ctl(SRC_QUAD,  3'd4, 1'b0, 1'b0);
      5'd1:    c = mk_ctl(SRC_QUAD,  3'd3, 1'b0, 1'b0);
      5'd2:    c = mk_ctl(SRC_QUAD,  3'd2, 1'b0, 1'b0);
      5'd3:    c = mk_ctl(SRC_QUAD,  3'd1, 1'b0, 1'b0);
      5'd4:    c = mk_ctl(SRC_QUAD,  3'd0, 1'b0, 1'b0);
      5'd5:    c = mk_ctl(SRC_YEAR,  3'd0, 1'b1, 1'b0);
      5'd6:    c = mk_ctl(SRC_MONTH, 3'd0, 1'b1, 1'b0);
      5'd7:    c = mk_ctl(SRC_DAY,   3'd4, 1'b0, 1'b0);
      5'd8:    c = mk_ctl(SRC_DAY,   3'd3, 1'b0, 1'b0);
      5'd9:    c = mk_ctl(SRC_DAY,   3'd2, 1'b0, 1'b0);
      5'd10:   c = mk_ctl(SRC_DAY,   3'd1, 1'b0, 1'b0);
      5'd11:   c = mk_ctl(SRC_DAY,   3'd0, 1'b0, 1'b0);
      5'd12:   c = mk_ctl(SRC_HOUR,  3'd4, 1'b0, 1'b0);
      5'd13:   c = mk_ctl(SRC_HOUR,  3'd3, 1'b0, 1'b0);
      5'd14:   c = mk_ctl(SRC_HOUR,  3'd2, 1'b0, 1'b0);
      5'd15:   c = mk_ctl(SRC_HOUR,  3'd1, 1'b0, 1'b0);
      5'd16:   c = mk_ctl(SRC_HOUR,  3'd0, 1'b0, 1'b0);
      5'd17:   c = mk_ctl(SRC_MIN,   3'd5, 1'b0, 1'b0);
      5'd18:   c = mk_ctl(SRC_MIN,   3'd4, 1'b0, 1'b0);
      5'd19:   c = mk_ctl(SRC_MIN,   3'd3, 1'b0, 1'b0);
      5'd20:   c = mk_ctl(SRC_MIN,   3'd2, 1'b0, 1'b0);
      5'd21:   c = mk_ctl(SRC_MIN,   3'd1, 1'b0, 1'b0);
      5'd22:   c = mk_ctl(SRC_MIN,   3'd0, 1'b0, 1'b1);
      default: c = mk_ctl(SRC_MIN,   3'd0, 1'b0, 1'b1);
    endcase
    return c;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (mon) inside
      FEBRUARY:                 d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [SEC_W-1:0] days_secs(input logic [DAY_W-1:0] days);
    logic [SEC_W-1:0] s;
    case (days)
      5'd28:   s = 31'd2419200;
      5'd29:   s = 31'd2505600;
      5'd30:   s = 31'd2592000;
      default: s = 31'd2678400;
    endcase
    return s;
  endfunction

  function automatic logic [WDAY_W-1:0] days_mod7(input logic [DAY_W-1:0] days);
    logic [WDAY_W-1:0] m;
    case (days)
      5'd28:   m = 3'd0;
      5'd29:   m = 3'd1;
      5'd30:   m = 3'd2;
      default: m = 3'd3;
    endcase
    return m;
  endfunction

  // Multiplies a residue modulo 7 by two, sh times.
  function automatic logic [WDAY_W-1:0] scale_mod7(input logic [WDAY_W-1:0] val,
                                                   input logic [SHIFT_W-1:0] sh);
    logic [WDAY_W:0] v;
    v = {1'b0, val};
    for (int i = 0; i < MAX_SHIFT; i++) begin
      if (SHIFT_W'(i) < sh) begin
        v = {v[WDAY_W-1:0], 1'b0};
        if (v >= 4'd7) begin
          v = v - 4'd7;
        end
      end
    end
    return v[WDAY_W-1:0];
  endfunction

endpackage

// ----- src/ecal_in_if.sv -----
// Input channel of the calendar converter: valid, ready and the seconds word.
// Depends on ecal_pkg.
interface ecal_in_if;
  import ecal_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] seconds;

  modport source (output valid, output seconds, input ready);
  modport sink   (input valid, input seconds, output ready);
endinterface

// ----- src/ecal_out_if.sv -----
// Result channel of the calendar converter: valid, ready and the date fields.
// Depends on ecal_pkg.
interface ecal_out_if;
  import ecal_pkg::*;

  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] year;
  logic [MON_W-1:0]  month;
  logic [DAY_W-1:0]  day;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [MIN_W-1:0]  second;
  logic [WDAY_W-1:0] weekday;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output weekday, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input weekday, output ready);
endinterface

// ----- src/ecal_seq.sv -----
// Microcode sequencer: step counter, control-store lookup and the
// accept/run/finish state machine. Depends on ecal_pkg.
module ecal_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ecal_pkg::dp_stat_t stat,
  output ecal_pkg::dp_cmd_t  cmd
);
  import ecal_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctl_t              ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    ctl          = ctl_rom(step_r);
    state_nxt    = state_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.ctl      = ctl;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.exec = 1'b1;
        if (stat.taken && ctl.rpt) begin
          step_nxt = step_r;
        end else if (ctl.last) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        // Wait here only while the previous word still sits unread.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ecal_dp.sv -----
// Datapath of the calendar converter: remaining-seconds register with one
// scaled compare/subtract, field counters, weekday residue and output register.
// Depends on ecal_pkg and ecal_out_if.
module ecal_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ecal_pkg::dp_cmd_t        cmd,
  input  logic [ecal_pkg::SEC_W-1:0] seconds,
  output ecal_pkg::dp_stat_t       stat,
  ecal_out_if.source               out_ch
);
  import ecal_pkg::*;

  logic [SEC_W-1:0]  t_r, t_nxt;
  logic [YRS_W-1:0]  yrs_r, yrs_nxt;
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [DAY_W-1:0]  dcnt_r, dcnt_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [WDAY_W-1:0] wk_r, wk_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0] year_out_r;
  logic [MON_W-1:0]  month_out_r;
  logic [DAY_W-1:0]  day_out_r;
  logic [HOUR_W-1:0] hour_out_r;
  logic [MIN_W-1:0]  minute_out_r;
  logic [MIN_W-1:0]  second_out_r;
  logic [WDAY_W-1:0] weekday_out_r;

  logic              leap;
  logic [DAY_W-1:0]  mdays;
  logic [SEC_W-1:0]  base;
  logic [SEC_W-1:0]  k;
  logic [WDAY_W-1:0] bmod;
  logic [WDAY_W-1:0] wk_add;
  logic [WDAY_W:0]   wk_sum;
  logic [INC_W-1:0]  inc;
  logic              taken;

  assign leap  = (yrs_r[1:0] == 2'd2);
  assign mdays = month_days(mon_r, leap);

  always_comb begin
    case (cmd.ctl.src)
      SRC_QUAD: begin
        base = SECS_PER_QUAD;
        bmod = QUAD_MOD7;
      end
      SRC_YEAR: begin
        base = leap ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
        bmod = leap ? LEAP_YEAR_MOD7 : YEAR_MOD7;
      end
      SRC_MONTH: begin
        base = days_secs(mdays);
        bmod = days_mod7(mdays);
      end
      SRC_DAY: begin
        base = SECS_PER_DAY;
        bmod = DAY_MOD7;
      end
      SRC_HOUR: begin
        base = SECS_PER_HOUR;
        bmod = NONE_MOD7;
      end
      default: begin
        base = SECS_PER_MIN;
        bmod = NONE_MOD7;
      end
    endcase
  end

  always_comb begin
    k      = base << cmd.ctl.shift;
    // December is never passed over, whatever remains.
    taken  = (t_r >= k) && !((cmd.ctl.src == SRC_MONTH) && (mon_r == LAST_MONTH));
    inc    = (cmd.ctl.src == SRC_QUAD) ? (INC_W'(4) << cmd.ctl.shift)
                                       : (INC_W'(1) << cmd.ctl.shift);
    wk_add = scale_mod7(bmod, cmd.ctl.shift);
    wk_sum = {1'b0, wk_r} + {1'b0, wk_add};

    t_nxt    = t_r;
    yrs_nxt  = yrs_r;
    mon_nxt  = mon_r;
    dcnt_nxt = dcnt_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    wk_nxt   = wk_r;
    if (cmd.load) begin
      t_nxt    = seconds;
      yrs_nxt  = '0;
      mon_nxt  = '0;
      dcnt_nxt = '0;
      hour_nxt = '0;
      min_nxt  = '0;
      wk_nxt   = '0;
    end else if (cmd.exec && taken) begin
      t_nxt  = t_r - k;
      wk_nxt = (wk_sum >= 4'd7) ? WDAY_W'(wk_sum - 4'd7) : wk_sum[WDAY_W-1:0];
      case (cmd.ctl.src)
        SRC_QUAD, SRC_YEAR: yrs_nxt  = yrs_r + inc;
        SRC_MONTH:          mon_nxt  = mon_r + inc[MON_W-1:0];
        SRC_DAY:            dcnt_nxt = dcnt_r + inc[DAY_W-1:0];
        SRC_HOUR:           hour_nxt = hour_r + inc[HOUR_W-1:0];
        default:            min_nxt  = min_r + inc[MIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.taken    = taken;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    yrs_r  <= yrs_nxt;
    mon_r  <= mon_nxt;
    dcnt_r <= dcnt_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    wk_r   <= wk_nxt;
    if (cmd.out_load) begin
      year_out_r    <= EPOCH_YEAR + YEAR_W'(yrs_r);
      month_out_r   <= mon_r;
      day_out_r     <= dcnt_r + 1'b1;
      hour_out_r    <= hour_r;
      minute_out_r  <= min_r;
      second_out_r  <= t_r[MIN_W-1:0];
      weekday_out_r <= wk_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.year    = year_out_r;
  assign out_ch.month   = month_out_r;
  assign out_ch.day     = day_out_r;
  assign out_ch.hour    = hour_out_r;
  assign out_ch.minute  = minute_out_r;
  assign out_ch.second  = second_out_r;
  assign out_ch.weekday = weekday_out_r;

`ifndef SYNTHESIS
  a_month_in_year: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.ctl.src == SRC_MONTH) |->
      (t_r < (leap ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR)))
    else $error("remaining time exceeds a year during month steps");

  a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.ctl.src == SRC_DAY) |-> (t_r < days_secs(5'd31)))
    else $error("remaining time exceeds a month during day steps");

  a_hour_in_day: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.ctl.src == SRC_HOUR) |-> (t_r < SECS_PER_DAY))
    else $error("remaining time exceeds a day during hour steps");

  a_min_in_hour: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.ctl.src == SRC_MIN) |-> (t_r < SECS_PER_HOUR))
    else $error("remaining time exceeds an hour during minute steps");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result register not marked valid after load");
`endif

endmodule

// ----- src/epoch_seconds_to_calendar_core.sv -----
// Top level of the epoch seconds to calendar converter: sequencer plus datapath.
// Depends on ecal_pkg, ecal_in_if, ecal_out_if, ecal_seq and ecal_dp.
//
//   channel  | dir | word contents
//   ---------+-----+-----------------------------------------------------
//   in_ch    | in  | seconds (31 b)
//   out_ch   | out | year, month, day, hour, minute, second, weekday
//
// From acceptance to result a word passes the accept step, the 23 control steps
// with one repeat per whole year past the last four-year block (up to 3) and per
// whole month (up to 11), and the result-load step.
// All steps share the single compare/subtract against the remaining seconds.
// Reset clears the sequencer and the result valid flag; nothing else needs it.
// A new word is accepted while a result waits; a stalled result holds the
// next one in the finish step until the output register frees.
module epoch_seconds_to_calendar_core (
  input logic        clk,
  input logic        rst_n,
  ecal_in_if.sink    in_ch,
  ecal_out_if.source out_ch
);
  import ecal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ecal_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecal_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .seconds (in_ch.seconds),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/epoch_seconds_to_calendar_core_tb.sv -----
// Self-checking testbench for epoch_seconds_to_calendar_core: random bursty stimulus,
// a stalling result sink and a calendar predictor checked field by field.
// Depends on ecal_pkg, ecal_in_if, ecal_out_if and the core itself.
module epoch_seconds_to_calendar_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecal_pkg::*;

  localparam logic [SEC_W-1:0] MAX_SECONDS = 31'h7FFF_FFFF;
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [MIN_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } date_t;

  typedef struct {
    logic [SEC_W-1:0] secs;
    date_t            date;
  } due_t;

  typedef struct {
    logic [SEC_W-1:0] secs;
    bit               drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;

  ecal_in_if  in_ch ();
  ecal_out_if out_ch ();

  epoch_seconds_to_calendar_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t seconds_q[$];
  due_t  dates_due[$];
  int    errors = 0;
  logic  in_taken = 1'b0;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit year_has_leap_day(input int yrs);
    return ((yrs + 2) % 4) == 0;
  endfunction

  function automatic logic [SEC_W-1:0] month_secs(input logic [MON_W-1:0] mon,
                                                   input bit leap);
    int days;
    case (mon)
      FEBRUARY:            days = leap ? 29 : 28;
      4'd3, 4'd5, 4'd8, 4'd10: days = 30;
      default:             days = 31;
    endcase
    return SEC_W'(days) * SECS_PER_DAY;
  endfunction

  function automatic date_t calendar_of(input logic [SEC_W-1:0] secs);
    logic [SEC_W-1:0] rem;
    logic [SEC_W-1:0] span;
    logic [MON_W-1:0] mon;
    int               yrs;
    bit               leap;
    date_t            d;
    rem = secs;
    d.weekday = WDAY_W'((secs / SECS_PER_DAY) % 7);
    yrs = 0;
    span = SECS_PER_YEAR;
    if (year_has_leap_day(yrs)) span = SECS_PER_LEAP_YEAR;
    // A year is skipped only when the rest covers it, leap day included.
    while (rem >= span) begin
      rem = rem - span;
      yrs++;
      span = year_has_leap_day(yrs) ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
    end
    leap = year_has_leap_day(yrs);
    mon = '0;
    while (mon < LAST_MONTH && rem >= month_secs(mon, leap)) begin
      rem = rem - month_secs(mon, leap);
      mon++;
    end
    d.year   = EPOCH_YEAR + YEAR_W'(yrs);
    d.month  = mon;
    d.day    = DAY_W'(rem / SECS_PER_DAY + 1);
    rem      = rem % SECS_PER_DAY;
    d.hour   = HOUR_W'(rem / SECS_PER_HOUR);
    rem      = rem % SECS_PER_HOUR;
    d.minute = MIN_W'(rem / SECS_PER_MIN);
    d.second = MIN_W'(rem % SECS_PER_MIN);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input logic [SEC_W-1:0] secs);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d for %0d s", name, got, want, secs));
  endtask

  // Input acceptance and result checking share one block, so the expectation
  // queue is only ever pushed and popped here.
  always @(posedge clk) begin
    due_t  want;
    date_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        want.secs = in_ch.seconds;
        want.date = calendar_of(in_ch.seconds);
        dates_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dates_due.size() == 0) begin
          report_mismatch("result word with no expectation waiting");
        end else begin
          want = dates_due.pop_front();
          got.year    = out_ch.year;
          got.month   = out_ch.month;
          got.day     = out_ch.day;
          got.hour    = out_ch.hour;
          got.minute  = out_ch.minute;
          got.second  = out_ch.second;
          got.weekday = out_ch.weekday;
          check_field("year",    int'(got.year),    int'(want.date.year),    want.secs);
          check_field("month",   int'(got.month),   int'(want.date.month),   want.secs);
          check_field("day",     int'(got.day),     int'(want.date.day),     want.secs);
          check_field("hour",    int'(got.hour),    int'(want.date.hour),    want.secs);
          check_field("minute",  int'(got.minute),  int'(want.date.minute),  want.secs);
          check_field("second",  int'(got.second),  int'(want.date.second),  want.secs);
          check_field("weekday", int'(got.weekday), int'(want.date.weekday), want.secs);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps, fed from seconds_q
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    stim_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the current word until it is taken.
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (seconds_q.size() != 0 &&
                 !(seconds_q[0].drain && (dates_due.size() != 0 || out_ch.valid))) begin
      item = seconds_q.pop_front();
      in_ch.valid   <= 1'b1;
      in_ch.seconds <= item.secs;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      end else begin
        burst_left--;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating pattern that is reloaded now and then
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_cnt = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      pat_cnt++;
      if (pat_cnt % 128 == 0) begin
        // Bit 0 is kept set so that each pattern has a ready bit and no stall lasts a full rotation.
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        ready_pat = {ready_pat[0], ready_pat[15:1]};
      end
      out_ch.ready <= ready_pat[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_word(input longint value, input bit drain);
    stim_t s;
    s.secs  = (value > longint'(MAX_SECONDS)) ? MAX_SECONDS : SEC_W'(value);
    s.drain = drain;
    seconds_q.push_back(s);
  endtask

  initial begin
    longint days;
    int     yrs;
    int     kind;
    in_ch.valid   = 1'b0;
    in_ch.seconds = '0;
    out_ch.ready  = 1'b0;
    rst_n = 1'b0;

    // Directed words: field extremes, unit roll-overs, leap day handling.
    queue_word(0, 0);
    queue_word(1, 0);
    queue_word(59, 0);
    queue_word(60, 0);
    queue_word(3599, 0);
    queue_word(3600, 0);
    queue_word(86399, 0);
    queue_word(86400, 0);
    queue_word(31535999, 0);     // last second of 1970
    queue_word(31536000, 0);
    queue_word(68169599, 0);     // end of Feb 28 in a leap year
    queue_word(68169600, 0);     // Feb 29, 1972
    queue_word(94607999, 0);
    queue_word(94608000, 0);     // Dec 31 of a leap year: the year must not advance
    queue_word(94694399, 0);
    queue_word(94694400, 0);
    queue_word(946684799, 0);
    queue_word(951782400, 0);    // Feb 29, 2000
    queue_word(1230767999, 0);   // last second of a leap year
    queue_word(31'h7FFF_0000, 0);
    queue_word(31'h0000_FFFF, 0);
    queue_word(MAX_SECONDS - 1, 0);
    queue_word(MAX_SECONDS, 0);  // Tuesday, Jan 19 2038
    queue_word(0, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        queue_word(longint'($urandom) & longint'(MAX_SECONDS), 0);
      end else if (kind < 80) begin
        // Near a midnight, or at any time, on a random day.
        days = $urandom_range(0, 24855);
        case ($urandom_range(0, 3))
          0:       queue_word(days * 86400, 0);
          1:       queue_word(days * 86400 + 86399, 0);
          2:       queue_word(days * 86400 + $urandom_range(0, 3), 0);
          default: queue_word(days * 86400 + $urandom_range(0, 86399), 0);
        endcase
      end else begin
        // Around the end of February, the end of December or the start of January in a leap year.
        yrs = 4 * $urandom_range(0, 16) + 2;
        days = longint'(yrs) * 365 + (yrs + 1) / 4;
        case ($urandom_range(0, 2))
          0:       days = days + $urandom_range(58, 59);
          1:       days = days + $urandom_range(364, 365);
          default: days = days + $urandom_range(0, 1);
        endcase
        queue_word(days * 86400 + (($urandom_range(0, 1) == 0) ?
                   $urandom_range(0, 2) : $urandom_range(86397, 86399)), 0);
      end
      if ($urandom_range(0, 99) == 0) queue_word(longint'($urandom) & longint'(MAX_SECONDS), 1);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled at the rising edge, where the driver's falling-edge updates have settled.
    while (seconds_q.size() != 0 || in_ch.valid || dates_due.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && dates_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (dates_due.size() != 0) report_mismatch("expectations left over at end of run");
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ecal_pkg.sv
src/ecal_in_if.sv
src/ecal_out_if.sv
src/ecal_seq.sv
src/ecal_dp.sv
src/epoch_seconds_to_calendar_core.sv
tb/epoch_seconds_to_calendar_core_tb.sv
